// File: hdl/ipv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_pkg: shared types and constants of the address text validator
// Holds the character class record passed from classifier to evaluator,
// the verdict codes and the separator and group limits.
// ----------------------------------------------------------------------------
package ipv_pkg;

	// separator characters
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	// address form limits
	localparam int unsigned V4_DOTS      = 3;
	localparam int unsigned V6_COLONS    = 7;
	localparam int unsigned V4_GROUP_MAX = 3;
	localparam int unsigned V6_GROUP_MAX = 4;
	localparam int unsigned V4_LIMIT     = 256;
	localparam int unsigned LEN_SAT      = 5;
	localparam int unsigned DOT_SAT      = 7;
	localparam int unsigned COLON_SAT    = 15;

	// default depth of the queue between classifier and evaluator
	localparam int unsigned QUEUE_DEPTH = 2;

	// verdict codes
	typedef enum logic [1:0] {
		VERDICT_NONE = 2'd0,
		VERDICT_V4   = 2'd1,
		VERDICT_V6   = 2'd2
	} verdict_t;

	// classified character
	typedef struct packed {
		logic       is_dot;
		logic       is_colon;
		logic       is_dec;
		logic       is_hex;
		logic       is_zero;
		logic [3:0] digit;
		logic       last;
	} char_class_t;

endpackage

// File: hdl/ipv_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_char_if: character channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface ipv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// File: hdl/ipv_verdict_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_verdict_if: verdict channel
// Valid/ready channel carrying one 2-bit address verdict.
// ----------------------------------------------------------------------------
interface ipv_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

// File: hdl/ipv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_front: character classifier
// Accepts text characters and tags each as separator, decimal digit or hex
// digit before handing it to the queue.
// ----------------------------------------------------------------------------
module ipv_front (
	ipv_char_if.sink              chars,
	input  logic                  queue_ready,
	output logic                  push,
	output ipv_pkg::char_class_t  push_item
);

	// accept whenever the queue has room
	assign chars.ready = queue_ready;
	assign push        = chars.valid & queue_ready;

	// classify the byte
	always_comb begin
		push_item.is_dot   = (chars.char_code == ipv_pkg::CHAR_DOT);
		push_item.is_colon = (chars.char_code == ipv_pkg::CHAR_COLON);
		push_item.is_dec   = chars.char_code inside {[8'h30:8'h39]};
		push_item.is_hex   = chars.char_code inside {[8'h30:8'h39], [8'h41:8'h46],
			[8'h61:8'h66]};
		push_item.is_zero  = (chars.char_code == ipv_pkg::CHAR_ZERO);
		push_item.digit    = chars.char_code[3:0];
		push_item.last     = chars.end_of_text;
	end

endmodule

// File: hdl/ipv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_queue: classified character queue
// Small register FIFO that decouples the classifier from the evaluator.
// ----------------------------------------------------------------------------
module ipv_queue #(
	parameter int unsigned DEPTH = ipv_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ipv_pkg::char_class_t  push_item,
	output logic                  push_ready,
	input  logic                  pop,
	output logic                  pop_valid,
	output ipv_pkg::char_class_t  pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ipv_pkg::char_class_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];

	// store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/ipv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_back: address evaluator
// Pops classified characters, tracks group and separator state and loads
// the verdict register on the final character of each string.
// ----------------------------------------------------------------------------
module ipv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  ipv_pkg::char_class_t  pop_item,
	output logic                  pop,
	ipv_verdict_if.source         result
);

	logic [2:0] group_len_q;
	logic [9:0] group_val_q;
	logic       all_dec_q;
	logic       starts_zero_q;
	logic [2:0] dot_total_q;
	logic [3:0] colon_total_q;
	logic       v4_ok_q;
	logic       v6_ok_q;
	logic       out_valid_q;
	ipv_pkg::verdict_t verdict_q;

	logic [2:0] group_len_d;
	logic [9:0] group_val_d;
	logic       all_dec_d;
	logic       starts_zero_d;
	logic [2:0] dot_total_d;
	logic [3:0] colon_total_d;
	logic       v4_ok_d;
	logic       v6_ok_d;
	logic       grp_v4_q_ok;
	logic       grp_v6_q_ok;
	logic       grp_v4_d_ok;
	logic       grp_v6_d_ok;
	ipv_pkg::verdict_t verdict_d;

	function automatic logic group_v4_ok(input logic [2:0] len, input logic [9:0] val,
		input logic all_dec, input logic sz);
		logic ok;
		ok = (len >= 3'd1) && (len <= 3'(ipv_pkg::V4_GROUP_MAX)) && all_dec &&
			(val < 10'(ipv_pkg::V4_LIMIT)) && !(sz && (len > 3'd1));
		return ok;
	endfunction

	function automatic logic group_v6_ok(input logic [2:0] len);
		return (len >= 3'd1) && (len <= 3'(ipv_pkg::V6_GROUP_MAX));
	endfunction

	// take plain characters freely; a final character waits for the verdict register
	assign pop = pop_valid && (!pop_item.last || !out_valid_q || result.ready);

	assign result.valid   = out_valid_q;
	assign result.verdict = verdict_q;

	// close the current group against both forms
	assign grp_v4_q_ok = group_v4_ok(group_len_q, group_val_q, all_dec_q, starts_zero_q);
	assign grp_v6_q_ok = group_v6_ok(group_len_q);

	// apply one character to the running state
	always_comb begin
		group_len_d   = group_len_q;
		group_val_d   = group_val_q;
		all_dec_d     = all_dec_q;
		starts_zero_d = starts_zero_q;
		dot_total_d   = dot_total_q;
		colon_total_d = colon_total_q;
		v4_ok_d       = v4_ok_q;
		v6_ok_d       = v6_ok_q;
		if (pop_item.is_dot) begin
			v4_ok_d       = v4_ok_q & grp_v4_q_ok;
			v6_ok_d       = 1'b0;
			dot_total_d   = (dot_total_q == 3'(ipv_pkg::DOT_SAT)) ? dot_total_q :
				dot_total_q + 3'd1;
			group_len_d   = '0;
			group_val_d   = '0;
			all_dec_d     = 1'b1;
			starts_zero_d = 1'b0;
		end else if (pop_item.is_colon) begin
			v6_ok_d       = v6_ok_q & grp_v6_q_ok;
			v4_ok_d       = 1'b0;
			colon_total_d = (colon_total_q == 4'(ipv_pkg::COLON_SAT)) ? colon_total_q :
				colon_total_q + 4'd1;
			group_len_d   = '0;
			group_val_d   = '0;
			all_dec_d     = 1'b1;
			starts_zero_d = 1'b0;
		end else begin
			if ((group_len_q == 3'd0) && pop_item.is_zero) begin
				starts_zero_d = 1'b1;
			end
			if (group_len_q != 3'(ipv_pkg::LEN_SAT)) begin
				group_len_d = group_len_q + 3'd1;
			end
			if (!pop_item.is_dec) begin
				all_dec_d = 1'b0;
			end else if (group_len_d <= 3'(ipv_pkg::V4_GROUP_MAX)) begin
				// value stays below 1000 within three digits
				group_val_d = {group_val_q[6:0], 3'b000} + {group_val_q[8:0], 1'b0} +
					{6'd0, pop_item.digit};
			end
			if (!pop_item.is_hex) begin
				v6_ok_d = 1'b0;
			end
		end
	end

	// judge the whole string on its final character
	assign grp_v4_d_ok = group_v4_ok(group_len_d, group_val_d, all_dec_d, starts_zero_d);
	assign grp_v6_d_ok = group_v6_ok(group_len_d);

	always_comb begin
		if (v4_ok_d && grp_v4_d_ok && (dot_total_d == 3'(ipv_pkg::V4_DOTS)) &&
			(colon_total_d == 4'd0)) begin
			verdict_d = ipv_pkg::VERDICT_V4;
		end else if (v6_ok_d && grp_v6_d_ok && (colon_total_d == 4'(ipv_pkg::V6_COLONS)) &&
			(dot_total_d == 3'd0)) begin
			verdict_d = ipv_pkg::VERDICT_V6;
		end else begin
			verdict_d = ipv_pkg::VERDICT_NONE;
		end
	end

	// update string state; clear it after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_len_q   <= '0;
			group_val_q   <= '0;
			all_dec_q     <= 1'b1;
			starts_zero_q <= 1'b0;
			dot_total_q   <= '0;
			colon_total_q <= '0;
			v4_ok_q       <= 1'b1;
			v6_ok_q       <= 1'b1;
		end else if (pop) begin
			if (pop_item.last) begin
				group_len_q   <= '0;
				group_val_q   <= '0;
				all_dec_q     <= 1'b1;
				starts_zero_q <= 1'b0;
				dot_total_q   <= '0;
				colon_total_q <= '0;
				v4_ok_q       <= 1'b1;
				v6_ok_q       <= 1'b1;
			end else begin
				group_len_q   <= group_len_d;
				group_val_q   <= group_val_d;
				all_dec_q     <= all_dec_d;
				starts_zero_q <= starts_zero_d;
				dot_total_q   <= dot_total_d;
				colon_total_q <= colon_total_d;
				v4_ok_q       <= v4_ok_d;
				v6_ok_q       <= v6_ok_d;
			end
		end
	end

	// hold the verdict until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && pop_item.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.last) begin
			verdict_q <= verdict_d;
		end
	end

	// a verdict only appears after a final character was taken
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && pop_item.last))
		else $error("verdict raised without a final character");

	// state returns to its cleared form after a final character
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_item.last) |=> (group_len_q == 3'd0) && (dot_total_q == 3'd0) &&
		(colon_total_q == 4'd0) && v4_ok_q && v6_ok_q)
		else $error("string state not cleared after final character");

	// mixed separators rule out both forms
	a_mixed_sep: assert property (@(posedge clk) disable iff (!arst_n)
		((dot_total_q != 3'd0) && (colon_total_q != 4'd0)) |-> (!v4_ok_q && !v6_ok_q))
		else $error("mixed separators left a form open");

	// an empty group carries no digit history
	a_empty_group: assert property (@(posedge clk) disable iff (!arst_n)
		(group_len_q == 3'd0) |-> ((group_val_q == 10'd0) && all_dec_q && !starts_zero_q))
		else $error("empty group holds stale digit state");

endmodule

// File: hdl/ip_address_text_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_validator: IPv4 / IPv6 address text checker
// Reads an address string one character per transaction and returns one
// verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : sink channel, one ASCII byte per transaction; end_of_text marks
//            the final character of a string.
//   result : source channel, one verdict per string (0 neither, 1 IPv4,
//            2 IPv6), sent for the transaction that carried end_of_text.
//   Throughput is one character per cycle while the queue has room. A
//   character is classified on entry and held in a QUEUE_DEPTH-entry queue;
//   the evaluator takes one entry per cycle unless a final character waits
//   for the verdict register. The final character passes through the queue
//   register, then the verdict register, before the verdict turns valid.
//   The verdict sits in an output register; while the receiver stalls, the
//   evaluator keeps taking characters until it reaches the next final
//   character, and the queue then fills and chars.ready drops.
//   Reset clears the queue, the string state and the verdict valid flag; the
//   block accepts characters in the first cycle after reset is released.
//   Every string is judged on its own; state clears after each verdict.
// ----------------------------------------------------------------------------
module ip_address_text_validator #(
	parameter int unsigned QUEUE_DEPTH = ipv_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	ipv_char_if.sink       chars,
	ipv_verdict_if.source  result
);

	logic                 push;
	logic                 push_ready;
	logic                 pop;
	logic                 pop_valid;
	ipv_pkg::char_class_t push_item;
	ipv_pkg::char_class_t pop_item;

	// classify incoming characters
	ipv_front u_front (
		.chars       (chars),
		.queue_ready (push_ready),
		.push        (push),
		.push_item   (push_item)
	);

	// decouple classifier and evaluator
	ipv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	// evaluate strings and emit verdicts
	ipv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: sim/ipv_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv_verdict_checker: scoreboard of the address text validator
// Watches the character and verdict channels, keeps its own copy of the
// per-string state, works out the verdict due for each finished string and
// compares every verdict transaction against the oldest one still due.
// ----------------------------------------------------------------------------
module ipv_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	ipv_char_if         chars,
	ipv_verdict_if      result,
	output int          mismatches,
	output int unsigned verdicts_owed
);

	// string state, same widths as the block keeps
	logic [2:0] grp_len;
	logic [9:0] grp_val;
	logic       grp_dec;
	logic       grp_zero;
	logic [2:0] dot_cnt;
	logic [3:0] colon_cnt;
	logic       v4_alive;
	logic       v6_alive;

	ipv_pkg::verdict_t verdicts_due[$];

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches = mismatches + 1;
	endtask

	function automatic bit is_digit(input logic [7:0] c);
		return c >= ipv_pkg::CHAR_ZERO && c <= 8'h39;
	endfunction

	// 0-9, A-F, a-f
	function automatic bit is_hexdigit(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic bit v4_group_fits();
		return grp_len >= 1 && grp_len <= ipv_pkg::V4_GROUP_MAX && grp_dec &&
			grp_val < ipv_pkg::V4_LIMIT && !(grp_zero && grp_len > 1);
	endfunction

	function automatic bit v6_group_fits();
		return grp_len >= 1 && grp_len <= ipv_pkg::V6_GROUP_MAX;
	endfunction

	task automatic clear_group();
		grp_len  = '0;
		grp_val  = '0;
		grp_dec  = 1'b1;
		grp_zero = 1'b0;
	endtask

	task automatic clear_text();
		clear_group();
		dot_cnt   = '0;
		colon_cnt = '0;
		v4_alive  = 1'b1;
		v6_alive  = 1'b1;
	endtask

	// advance the string state by one character; queue a verdict on the last
	task automatic absorb_char(input logic [7:0] c, input logic last);
		ipv_pkg::verdict_t v;
		if (c == ipv_pkg::CHAR_DOT) begin
			if (!v4_group_fits()) v4_alive = 1'b0;
			v6_alive = 1'b0;
			if (dot_cnt < ipv_pkg::DOT_SAT) dot_cnt = dot_cnt + 3'd1;
			clear_group();
		end else if (c == ipv_pkg::CHAR_COLON) begin
			if (!v6_group_fits()) v6_alive = 1'b0;
			v4_alive = 1'b0;
			if (colon_cnt < ipv_pkg::COLON_SAT) colon_cnt = colon_cnt + 4'd1;
			clear_group();
		end else begin
			if (grp_len == 0 && c == ipv_pkg::CHAR_ZERO) grp_zero = 1'b1;
			if (grp_len < ipv_pkg::LEN_SAT) grp_len = grp_len + 3'd1;
			if (!is_digit(c)) begin
				grp_dec = 1'b0;
			end else if (grp_len <= ipv_pkg::V4_GROUP_MAX) begin
				grp_val = 10'(grp_val * 10 + (c - ipv_pkg::CHAR_ZERO));
			end
			if (!is_hexdigit(c)) v6_alive = 1'b0;
		end
		if (last) begin
			v = ipv_pkg::VERDICT_NONE;
			if (v4_alive && v4_group_fits() && dot_cnt == ipv_pkg::V4_DOTS &&
				colon_cnt == 0) begin
				v = ipv_pkg::VERDICT_V4;
			end else if (v6_alive && v6_group_fits() && colon_cnt == ipv_pkg::V6_COLONS &&
				dot_cnt == 0) begin
				v = ipv_pkg::VERDICT_V6;
			end
			verdicts_due = {verdicts_due, v};
			clear_text();
		end
	endtask

	// compare verdicts first: a verdict never belongs to a character of the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		ipv_pkg::verdict_t due;
		if (!arst_n) begin
			clear_text();
			verdicts_due.delete();
			verdicts_owed <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("verdict %0d with no string pending",
						result.verdict));
				end else begin
					due = verdicts_due.pop_front();
					if (result.verdict !== due) begin
						report_mismatch($sformatf("verdict %0d, expected %0d",
							result.verdict, due));
					end
				end
			end
			if (chars.valid && chars.ready) begin
				absorb_char(chars.char_code, chars.end_of_text);
			end
			verdicts_owed <= verdicts_due.size();
		end
	end

endmodule

// File: sim/tb_ip_address_text_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_address_text_validator: testbench of the address text validator
// Sends directed strings (group and separator extremes, saturation, high
// bytes), then random mostly well-formed IPv4 and IPv6 strings, edited copies of
// them and noise, with random gaps on both channels and long receiver stalls.
// The checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_ip_address_text_validator;

	typedef enum {
		EDIT_BYTE,
		EDIT_DOT,
		EDIT_COLON,
		EDIT_DROP,
		EDIT_ZERO,
		EDIT_HEX
	} edit_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          calm;
	int          mismatches;
	int unsigned verdicts_owed;
	int unsigned chars_sent;
	logic [7:0]  text_buf[$];

	ipv_char_if    chars_bus();
	ipv_verdict_if verdict_bus();

	ip_address_text_validator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.result (verdict_bus)
	);

	ipv_verdict_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars_bus),
		.result        (verdict_bus),
		.mismatches    (mismatches),
		.verdicts_owed (verdicts_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// end the run if it hangs
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [7:0] hex_char(input int unsigned n, input bit upper);
		if (n < 10) return 8'(ipv_pkg::CHAR_ZERO + n);
		// 'A' or 'a' based
		return 8'((upper ? 8'h41 : 8'h61) + n - 10);
	endfunction

	// add one byte at the tail of the text buffer
	task automatic append_char(input logic [7:0] c);
		text_buf = {text_buf, c};
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) append_char(s[i]);
	endtask

	task automatic push_decimal(input int unsigned val);
		if (val >= 100) append_char(8'(ipv_pkg::CHAR_ZERO + val / 100));
		if (val >= 10) append_char(8'(ipv_pkg::CHAR_ZERO + (val / 10) % 10));
		append_char(8'(ipv_pkg::CHAR_ZERO + val % 10));
	endtask

	task automatic build_v4();
		for (int g = 0; g < 4; g++) begin
			if (g != 0) append_char(ipv_pkg::CHAR_DOT);
			if ($urandom_range(0, 9) == 0) append_char(ipv_pkg::CHAR_ZERO);
			push_decimal($urandom_range(0, 9) == 0 ? $urandom_range(0, 999)
				: $urandom_range(0, 255));
		end
	endtask

	task automatic build_v6();
		int unsigned len;
		for (int g = 0; g < 8; g++) begin
			if (g != 0) append_char(ipv_pkg::CHAR_COLON);
			len = ($urandom_range(0, 11) == 0) ? 5 : $urandom_range(1, 4);
			for (int k = 0; k < len; k++) begin
				append_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
			end
		end
	endtask

	task automatic build_noise();
		int unsigned len;
		len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 8);
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 3))
				0: append_char(ipv_pkg::CHAR_DOT);
				1: append_char(ipv_pkg::CHAR_COLON);
				2: append_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
				default: append_char(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// edit a generated string at one random place
	task automatic edit_text();
		int unsigned pos;
		edit_kind_t  kind;
		pos  = $urandom_range(0, text_buf.size() - 1);
		kind = edit_kind_t'($urandom_range(0, 5));
		case (kind)
			EDIT_BYTE:  text_buf[pos] = 8'($urandom_range(0, 255));
			EDIT_DOT:   text_buf.insert(pos, ipv_pkg::CHAR_DOT);
			EDIT_COLON: text_buf.insert(pos, ipv_pkg::CHAR_COLON);
			EDIT_DROP:  if (text_buf.size() > 1) text_buf.delete(pos);
			EDIT_ZERO:  text_buf.insert(pos, ipv_pkg::CHAR_ZERO);
			default:    text_buf.insert(pos, hex_char($urandom_range(0, 15),
				1'($urandom_range(0, 1))));
		endcase
	endtask

	// offer one character and hold it until the transaction completes
	task automatic send_char(input logic [7:0] c, input logic last);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			chars_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_bus.valid       <= 1'b1;
		chars_bus.char_code   <= c;
		chars_bus.end_of_text <= last;
		@(posedge clk);
		while (!chars_bus.ready) @(posedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_char(text_buf[i], i == text_buf.size() - 1);
		end
		chars_sent += text_buf.size();
		text_buf.delete();
	endtask

	task automatic send_string(input string s);
		push_text(s);
		send_text();
	endtask

	// verdict receiver: random stalls, two long hold-offs
	initial begin : receiver
		int unsigned gap;
		int unsigned taken;
		taken = 0;
		verdict_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 40 || taken == 80) gap = 400;
			else if (calm) gap = 0;
			else gap = $urandom_range(0, 3);
			if (gap != 0) begin
				verdict_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			verdict_bus.ready <= 1'b1;
			@(posedge clk);
			while (!verdict_bus.valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		int unsigned wait_cycles;
		int unsigned string_no;
		int unsigned pick;
		chars_bus.valid       <= 1'b0;
		chars_bus.char_code   <= '0;
		chars_bus.end_of_text <= 1'b0;
		arst_n                <= 1'b0;
		calm       = 1'b0;
		chars_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// group value and leading zero extremes, empty groups
		send_string("0.0.0.0");
		send_string("255.255.255.255");
		send_string("256.10.10.10");
		send_string("01.2.3.4");
		send_string("1..2.3");
		send_string(".1.2.3");
		send_string("1.2.3.");
		send_string("1.2.3.4.5");
		send_string("1111.1.1.1");
		send_string("7");
		// hex of both cases, empty and long groups, extra separators
		send_string("ffff:FFFF:abcd:ABCD:0:9:eF:Fe");
		send_string(":1:2:3:4:5:6:7");
		send_string("1:2:3:4:5:6:7:");
		send_string("12345:1:2:3:4:5:6:7");
		send_string("1:2:3:4:5:6:7:g");
		send_string("1:2:3:4:5:6:7:8:9");
		// mixed separators
		send_string("1.2.3:4");
		send_string("1:2:3:4:5:6.7:8");
		// group length and separator counts past saturation
		send_string("123456789.1.1.1");
		send_string("123456789:1:1:1:1:1:1:1");
		send_string("1.1.1.1.1.1.1.1.1.1.1.1");
		for (int g = 0; g < 24; g++) begin
			if (g != 0) append_char(ipv_pkg::CHAR_COLON);
			append_char(8'(ipv_pkg::CHAR_ZERO + 1));
		end
		send_text();
		// bytes above 127
		push_text("1.2.3.");
		append_char(8'h80);
		send_text();
		push_text("a:b:c:d:e:f:0:");
		append_char(8'hFF);
		send_text();

		// random strings, mostly well-formed
		string_no = 0;
		while (chars_sent < 1500) begin
			calm = ((string_no / 15) % 5) == 3;
			pick = $urandom_range(0, 9);
			if (pick < 4) build_v4();
			else if (pick < 8) build_v6();
			else build_noise();
			if (pick < 8 && $urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 2)) edit_text();
			end
			send_text();
			string_no++;
		end
		calm = 1'b0;
		chars_bus.valid <= 1'b0;
		@(posedge clk);

		// drain outstanding verdicts, then watch for strays
		wait_cycles = 0;
		while (verdicts_owed != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (verdicts_owed != 0) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			repeat (8) @(posedge clk);
			if (mismatches == 0 && verdicts_owed == 0) begin
				$display("*** PASSED ***");
			end else begin
				$display("*** FAILED ***");
			end
			$finish;
		end
	end

endmodule
